FILE: rtl/core/adct8_pkg.sv
package adct8_pkg;

	// Default sample and coefficient width
	localparam int SAMPLE_WIDTH_DEF = 16;

	// Width of the a_select register
	localparam int A_SEL_W = 2;

	// Codes of the transform parameter a
	localparam logic [A_SEL_W-1:0] A_ZERO = 2'd0;
	localparam logic [A_SEL_W-1:0] A_HALF = 2'd1;
	localparam logic [A_SEL_W-1:0] A_ONE  = 2'd2;
	localparam logic [A_SEL_W-1:0] A_TWO  = 2'd3;

	// Value of a_select after reset
	localparam logic [A_SEL_W-1:0] A_SEL_RESET = A_ONE;

endpackage

FILE: rtl/core/approx_dct8_butterfly.sv
// A column accepted at the input passes through the butterfly b, butterfly c and scaled
// output registers before it is on the outputs; output stalls hold it in place.
// Throughput: one column per cycle while out_stall is low; three register stages (butterfly b, butterfly c,
// scaled output) each advance whenever the stage ahead is empty or moving.
// Reset (arst_n low, asynchronous): pipeline emptied, a_select set to A_ONE (a = 1).
module approx_dct8_butterfly #(
	parameter int SAMPLE_WIDTH = adct8_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [adct8_pkg::A_SEL_W-1:0]       cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_0,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_1,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_2,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_3,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_4,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_5,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_6,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_7,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      coef_0,
	output logic signed [SAMPLE_WIDTH-1:0]      coef_1,
	output logic signed [SAMPLE_WIDTH-1:0]      coef_2,
	output logic signed [SAMPLE_WIDTH-1:0]      coef_3,
	output logic signed [SAMPLE_WIDTH-1:0]      coef_4,
	output logic signed [SAMPLE_WIDTH-1:0]      coef_5,
	output logic signed [SAMPLE_WIDTH-1:0]      coef_6,
	output logic signed [SAMPLE_WIDTH-1:0]      coef_7
);

	localparam int W = SAMPLE_WIDTH;

	logic [adct8_pkg::A_SEL_W-1:0] a_sel_q;

	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	logic signed [W-1:0] b0_s1, b1_s1, b2_s1, b3_s1, b4_s1, b5_s1, b6_s1, b7_s1;
	logic signed [W-1:0] c0_s2, c1_s2, c2_s2, c3_s2, c6_s2, c7_s2, b4_s2, b5_s2;
	logic signed [W-1:0] c0_s3, c1_s3, c2_s3, c3_s3, c4_s3, c5_s3, c6_s3, c7_s3;

	logic [W-1:0] sc2, sc3;

	// Config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_sel_q <= adct8_pkg::A_SEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			a_sel_q <= cfg_data;
		end
	end

	// Stage advance: a stage moves when empty or when the next one moves
	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: first butterfly, pair sums and differences
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			b0_s1 <= sample_0 + sample_7;
			b1_s1 <= sample_1 + sample_6;
			b2_s1 <= sample_2 + sample_5;
			b3_s1 <= sample_3 + sample_4;
			b4_s1 <= sample_3 - sample_4;
			b5_s1 <= sample_2 - sample_5;
			b6_s1 <= sample_1 - sample_6;
			b7_s1 <= sample_0 - sample_7;
		end
	end

	// Stage 2: second butterfly
	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			c0_s2 <= b0_s1 + b3_s1;
			c1_s2 <= b1_s1 + b2_s1;
			c2_s2 <= b1_s1 - b2_s1;
			c3_s2 <= b0_s1 - b3_s1;
			c6_s2 <= b6_s1 + b7_s1;
			c7_s2 <= b7_s1 - b6_s1;
			b4_s2 <= b4_s1;
			b5_s2 <= b5_s1;
		end
	end

	// Shift-only scaling by a
	adct8_scale #(.W(W)) u_scale_c2 (
		.v   (c2_s2),
		.sel (a_sel_q),
		.y   (sc2)
	);

	adct8_scale #(.W(W)) u_scale_c3 (
		.v   (c3_s2),
		.sel (a_sel_q),
		.y   (sc3)
	);

	// Stage 3: final butterfly and output reorder
	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			c0_s3 <= c0_s2 + c1_s2;
			c1_s3 <= c6_s2;
			c2_s3 <= signed'(sc2);
			c3_s3 <= b5_s2;
			c4_s3 <= c0_s2 - c1_s2;
			c5_s3 <= b4_s2;
			c6_s3 <= c7_s2;
			c7_s3 <= signed'(sc3) - c2_s2;
		end
	end

	assign out_valid = valid_s3;
	assign coef_0    = c0_s3;
	assign coef_1    = c1_s3;
	assign coef_2    = c2_s3;
	assign coef_3    = c3_s3;
	assign coef_4    = c4_s3;
	assign coef_5    = c5_s3;
	assign coef_6    = c6_s3;
	assign coef_7    = c7_s3;

	// Input is stalled only when every stage holds a transaction
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3))
		else $error("in_stall with a bubble in the pipeline");

	// A transaction in stage 2 that moves reaches the output register
	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv3) |=> valid_s3)
		else $error("stage 2 transaction lost");

	// A delivered result with nothing behind it leaves the output empty
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !out_stall && !valid_s2) |=> !valid_s3)
		else $error("result repeated");

endmodule

FILE: rtl/core/adct8_scale.sv
// Multiply a wrapped two's complement value by a in {0, 0.5, 1, 2} with shifts only
module adct8_scale #(
	parameter int W = adct8_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic [W-1:0]                   v,
	input  logic [adct8_pkg::A_SEL_W-1:0]  sel,
	output logic [W-1:0]                   y
);

	// half rounds toward minus infinity; double wraps
	always_comb begin
		unique case (sel)
			adct8_pkg::A_ZERO: y = '0;
			adct8_pkg::A_HALF: y = {v[W-1], v[W-1:1]};
			adct8_pkg::A_ONE:  y = v;
			adct8_pkg::A_TWO:  y = {v[W-2:0], 1'b0};
			default:           y = v;
		endcase
	end

endmodule

FILE: dv/tb_approx_dct8_butterfly.sv
module tb_approx_dct8_butterfly;

	localparam int W = adct8_pkg::SAMPLE_WIDTH_DEF;
	localparam int QUIET_LIMIT = 2000;

	typedef logic [W-1:0] word_t;
	typedef logic [7:0][W-1:0] column_t;
	typedef logic [adct8_pkg::A_SEL_W-1:0] sel_t;

	localparam word_t WORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(W-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	sel_t cfg_data = adct8_pkg::A_SEL_RESET;

	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [W-1:0] sample_0 = '0;
	logic signed [W-1:0] sample_1 = '0;
	logic signed [W-1:0] sample_2 = '0;
	logic signed [W-1:0] sample_3 = '0;
	logic signed [W-1:0] sample_4 = '0;
	logic signed [W-1:0] sample_5 = '0;
	logic signed [W-1:0] sample_6 = '0;
	logic signed [W-1:0] sample_7 = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [W-1:0] coef_0;
	logic signed [W-1:0] coef_1;
	logic signed [W-1:0] coef_2;
	logic signed [W-1:0] coef_3;
	logic signed [W-1:0] coef_4;
	logic signed [W-1:0] coef_5;
	logic signed [W-1:0] coef_6;
	logic signed [W-1:0] coef_7;

	// Shadow of the a_select register and coefficient columns still owed by the block
	sel_t a_sel_now = adct8_pkg::A_SEL_RESET;
	column_t pending_coefs[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	bit full_rate = 1'b0;

	approx_dct8_butterfly #(
		.SAMPLE_WIDTH(W)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample_0 (sample_0),
		.sample_1 (sample_1),
		.sample_2 (sample_2),
		.sample_3 (sample_3),
		.sample_4 (sample_4),
		.sample_5 (sample_5),
		.sample_6 (sample_6),
		.sample_7 (sample_7),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.coef_0   (coef_0),
		.coef_1   (coef_1),
		.coef_2   (coef_2),
		.coef_3   (coef_3),
		.coef_4   (coef_4),
		.coef_5   (coef_5),
		.coef_6   (coef_6),
		.coef_7   (coef_7)
	);

	always #5 clk = ~clk;

	// Multiply by a with shifts only; the half case rounds toward minus infinity
	function automatic word_t scale_by_a(word_t v, sel_t sel);
		case (sel)
			adct8_pkg::A_ZERO: return '0;
			adct8_pkg::A_HALF: return {v[W-1], v[W-1:1]};
			adct8_pkg::A_ONE:  return v;
			adct8_pkg::A_TWO:  return {v[W-2:0], 1'b0};
			default: return 'x;
		endcase
	endfunction

	// Three butterfly stages, every sum wrapping at W bits, then the output reorder
	function automatic column_t dct_column(column_t x, sel_t sel);
		word_t b0, b1, b2, b3, b4, b5, b6, b7;
		word_t c0, c1, c2, c3, c6, c7;
		column_t y;
		b0 = x[0] + x[7];
		b1 = x[1] + x[6];
		b2 = x[2] + x[5];
		b3 = x[3] + x[4];
		b4 = x[3] - x[4];
		b5 = x[2] - x[5];
		b6 = x[1] - x[6];
		b7 = x[0] - x[7];
		c0 = b0 + b3;
		c1 = b1 + b2;
		c2 = b1 - b2;
		c3 = b0 - b3;
		c6 = b6 + b7;
		c7 = b7 - b6;
		y[0] = c0 + c1;
		y[1] = c6;
		y[2] = scale_by_a(c2, sel);
		y[3] = b5;
		y[4] = c0 - c1;
		y[5] = b4;
		y[6] = c7;
		y[7] = word_t'(scale_by_a(c3, sel) - c2);
		return y;
	endfunction

	// Sample mix: rails, values near zero, and full-range noise
	function automatic word_t rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return WORD_MAX;
		if (r == 1) return WORD_MIN;
		if (r == 2) return word_t'(int'($urandom_range(0, 7)) - 4);
		return word_t'($urandom);
	endfunction

	function automatic column_t rand_column();
		column_t col;
		for (int i = 0; i < 8; i++)
			col[i] = rand_sample();
		return col;
	endfunction

	// Idle cycles before the next column: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (full_rate)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Send one column; valid stays high after the transaction so back-to-back
	// columns need no extra edge
	task automatic send_column(input column_t col);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_0 <= col[0];
		sample_1 <= col[1];
		sample_2 <= col[2];
		sample_3 <= col[3];
		sample_4 <= col[4];
		sample_5 <= col[5];
		sample_6 <= col[6];
		sample_7 <= col[7];
		do @(posedge clk); while (in_stall);
		pending_coefs.push_back(dct_column(col, a_sel_now));
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_coefs.size() != 0);
	endtask

	// Register write only once the pipeline is empty
	task automatic set_a_select(input sel_t code);
		drain_pipeline();
		cfg_valid <= 1'b1;
		cfg_data <= code;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		a_sel_now = code;
	endtask

	// Rails and wrap-heavy columns under the reset value of a
	task automatic test_reset_value();
		send_column('0);
		send_column({8{WORD_MAX}});
		send_column({8{WORD_MIN}});
		send_column({WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
			WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX});
		send_column({4{WORD_MIN, WORD_MAX}});
		send_column({4{word_t'('1), word_t'('0)}});
	endtask

	// Each a code: odd negative terms for the half rounding, big terms for the doubling wrap
	task automatic test_a_codes();
		sel_t codes [4];
		column_t col;
		codes = '{adct8_pkg::A_ZERO, adct8_pkg::A_HALF, adct8_pkg::A_ONE, adct8_pkg::A_TWO};
		for (int k = 0; k < 4; k++) begin
			set_a_select(codes[k]);
			col = '0;
			col[1] = word_t'(-3);
			col[0] = word_t'(-5);
			send_column(col);
			col = '0;
			col[1] = word_t'(24576);
			col[0] = word_t'(16384);
			send_column(col);
			send_column(rand_column());
		end
	endtask

	// Random columns under idling on both sides, a reselected now and then
	task automatic test_random_columns();
		for (int n = 0; n < 400; n++) begin
			if (n % 40 == 0)
				set_a_select(sel_t'($urandom_range(0, 3)));
			send_column(rand_column());
		end
	endtask

	// Full rate: no gaps and no output stalls
	task automatic test_full_rate();
		set_a_select(adct8_pkg::A_TWO);
		full_rate = 1'b1;
		for (int n = 0; n < 80; n++)
			send_column(rand_column());
		full_rate = 1'b0;
	endtask

	// Output stall pattern: runs of flow, short stalls, occasional long ones
	always begin : out_stall_pattern
		int r;
		r = $urandom_range(0, 99);
		if (full_rate || r < 55) begin
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end else if (r < 92) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end else begin
			out_stall <= 1'b1;
			repeat ($urandom_range(10, 40)) @(posedge clk);
		end
	end

	// Compare each result transaction with the oldest pending column
	always @(posedge clk) begin : check_coefs
		column_t want;
		column_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {coef_7, coef_6, coef_5, coef_4, coef_3, coef_2, coef_1, coef_0};
			if (pending_coefs.size() == 0) begin
				$error("result transaction with no pending column");
				mismatch_count++;
			end else begin
				want = pending_coefs.pop_front();
				for (int i = 0; i < 8; i++) begin
					if (got[i] !== want[i]) begin
						$error("coef_%0d: expected %0d, got %0d",
							i, $signed(want[i]), $signed(got[i]));
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_value();
		test_a_codes();
		test_random_columns();
		test_full_rate();
		drain_pipeline();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_coefs.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/adct8_pkg.sv
rtl/core/adct8_scale.sv
rtl/core/approx_dct8_butterfly.sv
dv/tb_approx_dct8_butterfly.sv
